// ===== hw/rtl/ftmc_pkg.sv =====
package ftmc_pkg;

	// framing characters and limits
	localparam logic [7:0] BAR              = 8'h7C;
	localparam logic [7:0] ZERO_CHAR        = 8'h30;
	localparam logic [6:0] LEN_MIN          = 7'd5;
	localparam logic [6:0] LEN_MAX          = 7'd99;
	localparam logic [6:0] NAME_LIMIT_RESET = 7'd72;

	// positions of the header bytes, of the last type letter and of the separator after the type
	localparam logic [6:0] POS_VERSION   = 7'd0;
	localparam logic [6:0] POS_BAR_ONE   = 7'd1;
	localparam logic [6:0] POS_TENS      = 7'd2;
	localparam logic [6:0] POS_UNITS     = 7'd3;
	localparam logic [6:0] POS_BAR_TWO   = 7'd4;
	localparam logic [6:0] POS_TYPE_LAST = 7'd8;
	localparam logic [6:0] POS_TYPE_SEP  = 7'd9;

	// configuration register indexes
	localparam logic REG_MAX_NAME_LENGTH = 1'b0;

	typedef enum logic [2:0] {
		KIND_OPEN    = 3'd0,
		KIND_WAIT    = 3'd1,
		KIND_NAME    = 3'd2,
		KIND_PLAY    = 3'd3,
		KIND_MOVE    = 3'd4,
		KIND_OVER    = 3'd5,
		KIND_FAIL    = 3'd6,
		KIND_UNKNOWN = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_VALID    = 2'd0,
		STATUS_INVALID  = 2'd1,
		STATUS_NAME_LONG = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		kind_t       message_kind;
		logic [6:0]  total_bytes;
		logic [1:0]  num_fields;
		logic [6:0]  first_field_length;
		logic [6:0]  second_field_length;
		logic [6:0]  third_field_length;
	} result_t;

	localparam logic [31:0] KIND_WORDS [7] = '{
		"OPEN", "WAIT", "NAME", "PLAY", "MOVE", "OVER", "FAIL"
	};

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	// match the four type letters against the known message types
	function automatic kind_t kind_decode(input logic [23:0] prefix, input logic [7:0] last);
		kind_t k;
		k = KIND_UNKNOWN;
		for (int i = 6; i >= 0; i--) begin
			if ({prefix, last} == KIND_WORDS[i]) k = kind_t'(3'(i));
		end
		return k;
	endfunction

	// number of fields each message type carries
	function automatic logic [1:0] kind_fields(input kind_t k);
		logic [1:0] n;
		case (k)
			KIND_OPEN: n = 2'd1;
			KIND_WAIT: n = 2'd0;
			KIND_NAME: n = 2'd2;
			KIND_PLAY: n = 2'd2;
			KIND_MOVE: n = 2'd2;
			KIND_OVER: n = 2'd3;
			KIND_FAIL: n = 2'd1;
			default:   n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== hw/rtl/ftmc_if.sv =====
interface ftmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface ftmc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] message_kind;
	logic [6:0] total_bytes;
	logic [1:0] num_fields;
	logic [6:0] first_field_length;
	logic [6:0] second_field_length;
	logic [6:0] third_field_length;

	modport source (
		output valid, output status, output message_kind, output total_bytes,
		output num_fields, output first_field_length, output second_field_length,
		output third_field_length, input ready
	);
	modport sink (
		input valid, input status, input message_kind, input total_bytes,
		input num_fields, input first_field_length, input second_field_length,
		input third_field_length, output ready
	);
endinterface

// ===== hw/rtl/ftmc_cfg.sv =====
module ftmc_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [6:0]  max_name_length
);

	logic [6:0] max_name_length_q;
	logic       wr_en;
	logic       sel_name;

	assign pready   = 1'b1;
	assign sel_name = (paddr[2] == ftmc_pkg::REG_MAX_NAME_LENGTH);
	assign wr_en    = psel & penable & pwrite & pready;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_length_q <= ftmc_pkg::NAME_LIMIT_RESET;
		end else if (wr_en && sel_name) begin
			max_name_length_q <= pwdata[6:0];
		end
	end

	// read back
	assign prdata          = sel_name ? {25'd0, max_name_length_q} : 32'd0;
	assign max_name_length = max_name_length_q;

endmodule

// ===== hw/rtl/ftmc_parser.sv =====
module ftmc_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_take,
	input  logic [7:0]        data_byte,
	input  logic [6:0]        max_name_length,
	output logic              res_valid,
	output ftmc_pkg::result_t res
);

	logic [6:0]      pos_q;
	logic [6:0]      len_q;
	logic [3:0]      tens_q;
	logic            hdr_err_q;
	logic [23:0]     prefix_q;
	ftmc_pkg::kind_t kind_q;
	logic [1:0]      fidx_q;
	logic [6:0]      flen_q [3];
	logic            ferr_q;
	logic            nond_q;

	logic [6:0]      len_n;
	logic [3:0]      tens_n;
	logic            hdr_err_n;
	logic [23:0]     prefix_n;
	ftmc_pkg::kind_t kind_n;
	logic [1:0]      fidx_n;
	logic [6:0]      flen_n [3];
	logic            ferr_n;
	logic            nond_n;
	logic            hdr_done;
	logic            frame_done;
	logic            ferr_end;
	logic [1:0]      fc;
	logic            digit;

	assign digit = ftmc_pkg::is_digit(data_byte);
	assign fc    = ftmc_pkg::kind_fields(kind_q);

	// per-byte update of the parse state
	always_comb begin
		len_n     = len_q;
		tens_n    = tens_q;
		hdr_err_n = hdr_err_q;
		prefix_n  = prefix_q;
		kind_n    = kind_q;
		fidx_n    = fidx_q;
		flen_n    = flen_q;
		ferr_n    = ferr_q;
		nond_n    = nond_q;
		hdr_done  = 1'b0;
		case (pos_q)
			ftmc_pkg::POS_VERSION: begin
				if (data_byte != ftmc_pkg::ZERO_CHAR) hdr_err_n = 1'b1;
			end
			ftmc_pkg::POS_BAR_ONE: begin
				if (data_byte != ftmc_pkg::BAR) hdr_err_n = 1'b1;
			end
			ftmc_pkg::POS_TENS: begin
				if (digit) begin
					tens_n = data_byte[3:0];
				end else begin
					hdr_err_n = 1'b1;
					tens_n    = 4'd0;
				end
			end
			ftmc_pkg::POS_UNITS: begin
				if (digit) begin
					len_n = 7'({3'd0, tens_q} * 7'd10 + {3'd0, data_byte[3:0]});
				end else begin
					hdr_err_n = 1'b1;
					len_n     = 7'd0;
				end
			end
			ftmc_pkg::POS_BAR_TWO: begin
				if (data_byte != ftmc_pkg::BAR || len_q < ftmc_pkg::LEN_MIN ||
						len_q > ftmc_pkg::LEN_MAX)
					hdr_err_n = 1'b1;
				hdr_done = hdr_err_n;
			end
			ftmc_pkg::POS_TYPE_LAST: begin
				kind_n = ftmc_pkg::kind_decode(prefix_q, data_byte);
			end
			ftmc_pkg::POS_TYPE_SEP: begin
				if (data_byte != ftmc_pkg::BAR) ferr_n = 1'b1;
			end
			default: begin
				if (pos_q < ftmc_pkg::POS_TYPE_LAST) begin
					// first three type letters
					prefix_n = {prefix_q[15:0], data_byte};
				end else if (fidx_q < fc) begin
					// field bytes and field terminators
					if (data_byte == ftmc_pkg::BAR) begin
						fidx_n = fidx_q + 2'd1;
					end else begin
						for (int i = 0; i < 3; i++) begin
							if (fidx_q == 2'(i)) flen_n[i] = flen_q[i] + 7'd1;
						end
						if (kind_q == ftmc_pkg::KIND_MOVE && !digit) nond_n = 1'b1;
					end
				end else begin
					ferr_n = 1'b1;
				end
			end
		endcase
	end

	// end of frame and verdict
	assign frame_done = (pos_q >= ftmc_pkg::POS_TYPE_SEP) &&
		({1'b0, pos_q} >= {1'b0, len_q} + 8'd4);
	assign ferr_end = ferr_n | (fidx_n != fc);

	always_comb begin
		res = '0;
		if (hdr_done) begin
			res.status       = ftmc_pkg::STATUS_INVALID;
			res.message_kind = ftmc_pkg::KIND_UNKNOWN;
			res.total_bytes  = 7'd5;
		end else begin
			if (kind_q == ftmc_pkg::KIND_UNKNOWN || ferr_end)
				res.status = ftmc_pkg::STATUS_INVALID;
			else if (kind_q == ftmc_pkg::KIND_OPEN && flen_n[0] > max_name_length)
				res.status = ftmc_pkg::STATUS_NAME_LONG;
			else if (kind_q == ftmc_pkg::KIND_MOVE && nond_n)
				res.status = ftmc_pkg::STATUS_INVALID;
			else
				res.status = ftmc_pkg::STATUS_VALID;
			res.message_kind        = kind_q;
			res.total_bytes         = pos_q + 7'd1;
			res.num_fields          = fc;
			res.first_field_length  = flen_n[0];
			res.second_field_length = flen_n[1];
			res.third_field_length  = flen_n[2];
		end
	end

	assign res_valid = byte_take & (hdr_done | frame_done);

	// parse state, cleared after every result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			tens_q    <= '0;
			hdr_err_q <= 1'b0;
			prefix_q  <= '0;
			kind_q    <= ftmc_pkg::KIND_OPEN;
			fidx_q    <= '0;
			flen_q    <= '{default: '0};
			ferr_q    <= 1'b0;
			nond_q    <= 1'b0;
		end else if (byte_take) begin
			if (hdr_done || frame_done) begin
				pos_q     <= '0;
				len_q     <= '0;
				tens_q    <= '0;
				hdr_err_q <= 1'b0;
				prefix_q  <= '0;
				kind_q    <= ftmc_pkg::KIND_OPEN;
				fidx_q    <= '0;
				flen_q    <= '{default: '0};
				ferr_q    <= 1'b0;
				nond_q    <= 1'b0;
			end else begin
				pos_q     <= pos_q + 7'd1;
				len_q     <= len_n;
				tens_q    <= tens_n;
				hdr_err_q <= hdr_err_n;
				prefix_q  <= prefix_n;
				kind_q    <= kind_n;
				fidx_q    <= fidx_n;
				flen_q    <= flen_n;
				ferr_q    <= ferr_n;
				nond_q    <= nond_n;
			end
		end
	end

endmodule

// ===== hw/rtl/ftmc_out_buf.sv =====
module ftmc_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  ftmc_pkg::result_t res,
	output logic              can_take,
	ftmc_result_if.source     result_out
);

	logic              out_valid_q;
	logic              skid_valid_q;
	ftmc_pkg::result_t out_q;
	ftmc_pkg::result_t skid_q;
	logic              pop;

	assign pop      = out_valid_q & result_out.ready;
	assign can_take = ~skid_valid_q;

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (res_valid) begin
			if (!out_valid_q || pop) out_q <= res;
			else skid_q <= res;
		end
	end

	assign result_out.valid               = out_valid_q;
	assign result_out.status              = out_q.status;
	assign result_out.message_kind        = out_q.message_kind;
	assign result_out.total_bytes         = out_q.total_bytes;
	assign result_out.num_fields          = out_q.num_fields;
	assign result_out.first_field_length  = out_q.first_field_length;
	assign result_out.second_field_length = out_q.second_field_length;
	assign result_out.third_field_length  = out_q.third_field_length;

endmodule

// ===== hw/rtl/framed_text_message_checker.sv =====
// Checks framed text messages one byte per transfer: header '0', '|', two length
// digits (5 to 99), '|', then a four-letter type, '|' and the type's '|'-terminated
// fields. One result transfer comes out for each frame, at its fifth byte when the
// header is bad and otherwise at its last byte; the parser then starts over with
// the next byte. A byte is taken every cycle while the skid entry is empty: the
// parse state updates once per byte and the result lands in an output register
// backed by one skid entry. Input stalls whenever the skid entry is full, which
// takes the sink holding ready low while the output register is full; after
// ready returns, input resumes in the next cycle. Each result is registered in
// the output register or, while it is full, in the skid entry. The name limit for
// open messages sits at byte addresses 0 to 3 of the config port, reset value 72.
module framed_text_message_checker (
	input  logic         clk,
	input  logic         arst_n,
	ftmc_byte_if.sink    byte_in,
	ftmc_result_if.source result_out,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic              byte_take;
	logic              can_take;
	logic              res_valid;
	logic [6:0]        max_name_length;
	ftmc_pkg::result_t res;

	assign byte_in.ready = can_take;
	assign byte_take     = byte_in.valid & can_take;

	// configuration registers
	ftmc_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.max_name_length (max_name_length)
	);

	// byte parser
	ftmc_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_take       (byte_take),
		.data_byte       (byte_in.data_byte),
		.max_name_length (max_name_length),
		.res_valid       (res_valid),
		.res             (res)
	);

	// result register
	ftmc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.can_take   (can_take),
		.result_out (result_out)
	);

endmodule
